FILE: sv/pds_pkg.sv
package pds_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CLK_W = 30;
    localparam int DIV_W = 31;

    localparam logic [1:0] OP_CONFIGURE = 2'd0;
    localparam logic [1:0] OP_ENABLE    = 2'd1;
    localparam logic [1:0] OP_DISABLE   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO      = 2'd1;
    localparam logic [1:0] STATUS_NO_DIVIDE = 2'd2;

    localparam logic [29:0] CLOCK_RESET = 30'd40000000;
    localparam logic [30:0] NS_PER_S    = 31'd1000000000;
    localparam logic [7:0]  MIN_TCNT    = 8'd100;
    localparam logic [15:0] MAX_TCNT    = 16'hFFF0;
    localparam logic [7:0]  TOP_PRESC   = 8'd255;
    localparam logic [7:0]  PRESC_STEP  = 8'd16;
    localparam logic [2:0]  TOP_MUX     = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE_START,
        ST_BASE_WAIT,
        ST_TRY_START,
        ST_TRY_WAIT,
        ST_FP_START,
        ST_FP_WAIT,
        ST_PER_START,
        ST_PER_WAIT,
        ST_DUTY_START,
        ST_DUTY_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  prescaler_setting;
        logic [2:0]  mux_setting;
        logic [30:0] period_count;
        logic [30:0] compare_count;
        logic [28:0] tick_rate_hz;
    } result_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  channel;
        logic [30:0] req_period;
        logic [30:0] duty_ns;
    } request_t;

endpackage

FILE: sv/pds_stream_if.sv
interface pds_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/pds_divider.sv
module pds_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [pds_pkg::DIV_W-1:0] dividend,
    input  logic [pds_pkg::DIV_W-1:0] divisor,
    output logic                    busy,
    output logic [pds_pkg::DIV_W-1:0] quotient
);
    import pds_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;
endmodule

FILE: sv/pwm_divider_search_core.sv
// Enable, disable, unused codes and a zero period go straight to the result.
// Configure: one 31-step division for the base rate, one per trial (up to 64)
// and one each for fp, period and duty.
// One item at a time: a request is taken only in idle, and all divisions share the single serial divider.
// The next item is accepted once the result transfer completes.
// Reset: running flags and group prescalers clear, clock register 40000000.
module pwm_divider_search_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [pds_pkg::CLK_W-1:0] cfg_wdata,
    pds_stream_if.sink              req,
    pds_stream_if.source            rsp
);
    import pds_pkg::*;

    state_t state_reg, state_next;
    logic [CLK_W-1:0] clock_reg;
    logic [NUM_CHANNELS-1:0] run_reg, run_next;
    logic [7:0] gp_reg [2];
    logic [7:0] gp_next [2];
    request_t req_reg;
    result_t res_reg, res_next;
    logic [7:0] presc_reg, presc_next;
    logic [2:0] mux_reg, mux_next;
    logic busy_mode_reg, busy_mode_next;
    logic [30:0] base_reg, base_next;
    logic [30:0] f_reg, f_next;
    logic [30:0] fp_reg, fp_next;
    logic div_start;
    logic [DIV_W-1:0] div_a, div_b, div_q;
    logic div_busy;
    logic [1:0] ch;
    logic grp;
    logic gbusy;
    logic [38:0] fmin;
    logic [46:0] fmax;
    logic hit;

    pds_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign ch   = req_reg.channel[1:0];
    assign grp  = ch[1];
    assign fmin = 39'(base_reg) * 39'(MIN_TCNT);
    assign fmax = 47'(base_reg) * 47'(MAX_TCNT);
    assign hit  = (fmin < 39'(div_q)) && (47'(div_q) < fmax);

    always_comb
    begin
        unique case (ch)
            2'd0: gbusy = run_reg[1];
            2'd1: gbusy = run_reg[0];
            2'd2: gbusy = run_reg[3] | run_reg[4];
            default: gbusy = run_reg[2] | run_reg[4];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        run_next = run_reg;
        gp_next = gp_reg;
        res_next = res_reg;
        presc_next = presc_reg;
        mux_next = mux_reg;
        busy_mode_next = busy_mode_reg;
        base_next = base_reg;
        f_next = f_reg;
        fp_next = fp_reg;
        div_start = 1'b0;
        div_a = NS_PER_S;
        div_b = req_reg.req_period;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_next = '0;
                    unique case (req.data.operation)
                        OP_ENABLE, OP_DISABLE:
                        begin
                            if (32'(req.data.channel) < NUM_CHANNELS)
                            begin
                                run_next[req.data.channel] =
                                    (req.data.operation == OP_ENABLE);
                            end
                            state_next = ST_DONE;
                        end
                        OP_CONFIGURE:
                        begin
                            if (req.data.req_period == '0)
                            begin
                                res_next.status = STATUS_ZERO;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_BASE_START;
                            end
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_BASE_START:
            begin
                div_start = 1'b1;
                busy_mode_next = gbusy;
                presc_next = gbusy ? gp_reg[grp] : TOP_PRESC;
                mux_next = TOP_MUX;
                state_next = ST_BASE_WAIT;
            end
            ST_BASE_WAIT:
            begin
                if (!div_busy)
                begin
                    base_next = div_q;
                    state_next = ST_TRY_START;
                end
            end
            ST_TRY_START:
            begin
                div_start = 1'b1;
                div_a = 31'(clock_reg >> mux_reg);
                div_b = 31'(presc_reg) + 31'd1;
                state_next = ST_TRY_WAIT;
            end
            ST_TRY_WAIT:
            begin
                if (!div_busy)
                begin
                    if (hit)
                    begin
                        f_next = div_q;
                        state_next = ST_FP_START;
                    end
                    else if (mux_reg != 3'd1)
                    begin
                        mux_next = mux_reg - 1'b1;
                        state_next = ST_TRY_START;
                    end
                    else if (!busy_mode_reg && presc_reg >= PRESC_STEP)
                    begin
                        mux_next = TOP_MUX;
                        presc_next = presc_reg - PRESC_STEP;
                        state_next = ST_TRY_START;
                    end
                    else
                    begin
                        res_next.status = STATUS_NO_DIVIDE;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FP_START:
            begin
                div_start = 1'b1;
                div_b = f_reg;
                state_next = ST_FP_WAIT;
            end
            ST_FP_WAIT:
            begin
                if (!div_busy)
                begin
                    fp_next = div_q;
                    state_next = ST_PER_START;
                end
            end
            ST_PER_START:
            begin
                div_start = 1'b1;
                div_a = req_reg.req_period;
                div_b = fp_reg;
                state_next = ST_PER_WAIT;
            end
            ST_PER_WAIT:
            begin
                if (!div_busy)
                begin
                    res_next.period_count = div_q;
                    state_next = ST_DUTY_START;
                end
            end
            ST_DUTY_START:
            begin
                div_start = 1'b1;
                div_a = req_reg.duty_ns;
                div_b = fp_reg;
                state_next = ST_DUTY_WAIT;
            end
            ST_DUTY_WAIT:
            begin
                if (!div_busy)
                begin
                    res_next.compare_count = div_q;
                    res_next.status = STATUS_OK;
                    res_next.prescaler_setting = presc_reg;
                    res_next.mux_setting = mux_reg;
                    res_next.tick_rate_hz = f_reg[28:0];
                    gp_next[grp] = presc_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clock_reg <= CLOCK_RESET;
            run_reg <= '0;
            gp_reg[0] <= '0;
            gp_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg <= run_next;
            gp_reg <= gp_next;
            if (cfg_we)
            begin
                clock_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid)
        begin
            req_reg <= req.data;
        end
        res_reg <= res_next;
        presc_reg <= presc_next;
        mux_reg <= mux_next;
        busy_mode_reg <= busy_mode_next;
        base_reg <= base_next;
        f_reg <= f_next;
        fp_reg <= fp_next;
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_DONE);
    assign rsp.data  = res_reg;
endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import pds_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CLK_W-1:0] cfg_wdata;

    pds_stream_if #(.payload_t(request_t)) req ();
    pds_stream_if #(.payload_t(result_t)) rsp ();

    pwm_divider_search_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req(req.sink),
        .rsp(rsp.source)
    );

    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        request_t rq;
        logic     known;
        result_t  res;
    } vector_t;

    logic [29:0] clock_hz;
    logic [7:0]  running;
    logic [7:0]  grp_presc [2];
    result_t     pending_results [$];
    vector_t     vectors [$];
    int          fail_count;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] tick_of(logic [2:0] mux, logic [7:0] presc);
        return ({34'd0, clock_hz} >> mux) / ({56'd0, presc} + 64'd1);
    endfunction

    function automatic result_t search_divider(request_t rq);
        result_t r;
        logic [1:0] ch;
        logic grp;
        logic busy;
        logic [63:0] base, fmin, fmax, f, fp;
        logic found;
        logic [7:0] presc;
        logic [2:0] mux;
        r = '0;
        ch = rq.channel[1:0];
        grp = ch[1];
        found = 1'b0;
        presc = '0;
        mux = '0;
        f = '0;
        if (rq.operation == OP_ENABLE || rq.operation == OP_DISABLE)
        begin
            if (rq.operation == OP_ENABLE)
                running[rq.channel] = 1'b1;
            else
                running[rq.channel] = 1'b0;
            return r;
        end
        if (rq.operation != OP_CONFIGURE)
            return r;
        if (rq.req_period == '0)
        begin
            r.status = STATUS_ZERO;
            return r;
        end
        case (ch)
            2'd0: busy = running[1];
            2'd1: busy = running[0];
            2'd2: busy = running[3] | running[4];
            default: busy = running[2] | running[4];
        endcase
        base = 64'd1000000000 / {33'd0, rq.req_period};
        fmin = base * 64'd100;
        fmax = base * 64'hFFF0;
        if (busy)
        begin
            for (int m = 4; m > 0 && !found; m--)
            begin
                f = tick_of(3'(m), grp_presc[grp]);
                if (fmin < f && f < fmax)
                begin
                    found = 1'b1;
                    mux = 3'(m);
                    presc = grp_presc[grp];
                end
            end
        end
        else
        begin
            for (int p = 255; p >= 0 && !found; p -= 16)
                for (int m = 4; m > 0 && !found; m--)
                begin
                    f = tick_of(3'(m), 8'(p));
                    if (fmin < f && f < fmax)
                    begin
                        found = 1'b1;
                        mux = 3'(m);
                        presc = 8'(p);
                    end
                end
        end
        if (!found)
        begin
            r.status = STATUS_NO_DIVIDE;
            return r;
        end
        fp = 64'd1000000000 / f;
        grp_presc[grp] = presc;
        r.status = STATUS_OK;
        r.prescaler_setting = presc;
        r.mux_setting = mux;
        r.period_count = 31'({33'd0, rq.req_period} / fp);
        r.compare_count = 31'({33'd0, rq.duty_ns} / fp);
        r.tick_rate_hz = f[28:0];
        return r;
    endfunction

    // receiver: random stall, compare each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, rsp.data);
                    fail_count++;
                end
                else
                begin
                    result_t e;
                    e = pending_results.pop_front();
                    if (e !== rsp.data)
                    begin
                        $display("%0t: expected %p actual %p", $time, e, rsp.data);
                        fail_count++;
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(request_t rq, logic known, result_t res);
        result_t pr;
        if ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= rq;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pr = search_divider(rq);
        if (known)
            pr = res;
        pending_results.push_back(pr);
    endtask

    task automatic drain_and_set(logic [29:0] hz);
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= hz;
        clock_hz = hz;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic request_t rand_request();
        request_t rq;
        int k;
        rq.operation = $urandom_range(99) < 55 ? OP_CONFIGURE : 2'($urandom_range(3));
        rq.channel = 3'($urandom_range(7));
        k = $urandom_range(9);
        if (k == 0)
            rq.req_period = 31'($urandom);
        else if (k == 1)
            rq.req_period = 31'($urandom_range(3));
        else
            rq.req_period = 31'($urandom_range(2000000, 1000) >> $urandom_range(4));
        rq.duty_ns = $urandom_range(9) == 0 ? 31'($urandom)
                                            : 31'($urandom_range(rq.req_period));
        return rq;
    endfunction

    function automatic void add_row(logic [1:0] op, logic [2:0] ch, logic [30:0] per,
                                    logic [30:0] duty, logic known, logic [1:0] st);
        vector_t v;
        v.rq = '{op, ch, per, duty};
        v.known = known;
        v.res = '0;
        v.res.status = st;
        vectors.push_back(v);
    endfunction

    initial
    begin
        logic [29:0] clocks [4];
        clk = 1'b0;
        fail_count = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.data = '0;
        clock_hz = CLOCK_RESET;
        running = '0;
        grp_presc[0] = 0;
        grp_presc[1] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(OP_CONFIGURE, 0, 0, 0, 1, STATUS_ZERO);
        add_row(OP_CONFIGURE, 7, 0, 31'h7FFFFFFF, 1, STATUS_ZERO);
        add_row(OP_CONFIGURE, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 1, STATUS_NO_DIVIDE);
        add_row(OP_CONFIGURE, 1, 1, 0, 1, STATUS_NO_DIVIDE);
        add_row(OP_CONFIGURE, 0, 1000000, 500000, 0, 0);
        add_row(OP_ENABLE, 1, 0, 0, 1, STATUS_OK);
        add_row(OP_CONFIGURE, 0, 200000, 300000, 0, 0);
        add_row(OP_CONFIGURE, 4, 50000, 0, 0, 0);
        add_row(OP_ENABLE, 4, 0, 0, 1, STATUS_OK);
        add_row(OP_CONFIGURE, 2, 20000, 10000, 0, 0);
        add_row(OP_CONFIGURE, 3, 1000000, 999999, 0, 0);
        add_row(2'd3, 5, 31'h7FFFFFFF, 31'h7FFFFFFF, 1, STATUS_OK);
        add_row(OP_ENABLE, 7, 31'h7FFFFFFF, 31'h7FFFFFFF, 1, STATUS_OK);
        add_row(OP_DISABLE, 4, 0, 0, 1, STATUS_OK);
        add_row(OP_DISABLE, 1, 0, 0, 1, STATUS_OK);
        add_row(OP_CONFIGURE, 6, 5000000, 6000000, 0, 0);
        foreach (vectors[i])
            send_item(vectors[i].rq, vectors[i].known, vectors[i].res);

        drain_and_set(30'd0);
        send_item('{OP_CONFIGURE, 3'd2, 31'd100000, 31'd5}, 1, '{STATUS_NO_DIVIDE, 0, 0, 0, 0, 0});

        clocks = '{30'd1000000000, 30'd1, 30'd40000000, 30'd12345678};
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_and_set(ph == 3 ? 30'($urandom_range(30'd1000000000, 1)) : clocks[ph]);
            idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 28 : 74) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 28 : 74) : 0;
            repeat (31)
                send_item(rand_request(), 0, '0);
        end

        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
